/* src/gfau_pkg.sv */
// ============================================================================
// gfau_pkg
// Shared types, constants and helper functions of the GF(2^8) arithmetic unit.
// ============================================================================
package gfau_pkg;

    // Reduction polynomial x^8 + x^4 + x^3 + x + 1.
    localparam logic [8:0] GF_POLY = 9'h11B;
    localparam logic [7:0] GF_POLY_LOW = 8'h1B;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_INV = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Status returned by a serial unit to the controller.
    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } t_unit_status;

    // Multiply a field element by x, reducing modulo the field polynomial.
    function automatic logic [7:0] f_xtime(input logic [7:0] value);
        logic [7:0] shifted;
        shifted = {value[6:0], 1'b0};
        f_xtime = value[7] ? (shifted ^ GF_POLY_LOW) : shifted;
    endfunction

    // Divide a field element by x, adding the polynomial first when it is odd.
    function automatic logic [7:0] f_half(input logic [7:0] value);
        logic [7:0] summed;
        summed = value ^ GF_POLY_LOW;
        f_half = value[0] ? {1'b1, summed[7:1]} : {1'b0, value[7:1]};
    endfunction

    // Degree of a nonzero 9-bit polynomial (0 for the zero polynomial).
    function automatic logic [3:0] f_degree(input logic [8:0] value);
        logic [3:0] deg;
        deg = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (value[i]) begin
                deg = 4'(i);
            end
        end
        f_degree = deg;
    endfunction

endpackage

/* src/gf256_field_arithmetic_unit_core.sv */
// ============================================================================
// gf256_field_arithmetic_unit_core
// GF(2^8) add, multiply and inverse unit over the polynomial 0x11B.
// ============================================================================
// Usage: an input transaction (i_valid / o_ready) carries a command and two
// byte operands; an output transaction (o_valid / i_ready) returns one byte.
// Command add returns a XOR b, multiply returns the reduced product, inverse
// returns the inverse of operand a (zero maps to zero). The reserved command
// returns zero.
// One transaction is processed at a time. Add and reserved results are
// computed at acceptance; multiply runs the bit-serial multiplier, one bit
// of b per cycle; the inverter marks the inverse of zero done on start, and
// any other inverse runs the binary Euclid loop that does one shift or one
// add per cycle. Each result then goes into the output register. o_ready
// rises in the same cycle as o_valid, so a new transaction cannot start
// before the last one has reached the output register.
// A finished result sits in an output register, so o_ready rises again while
// the result still waits; a stalled receiver only holds the next result in
// the unit until the output register frees up.
// Reset (synchronous, active low) empties the output register and returns
// the controller to idle; no clearing pass is needed.
// ============================================================================
module gf256_field_arithmetic_unit_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_field_result
);

    gfau_pkg::t_state r_state, n_state;

    // Command of the transaction in flight and the result of the add and reserved commands.
    logic [1:0] r_cmd, n_cmd;
    logic [7:0] r_quick, n_quick;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_result, n_result;

    logic       w_accept;
    logic       w_start_mul;
    logic       w_start_inv;
    logic       w_sel_done;
    logic [7:0] w_sel_result;

    gfau_pkg::t_unit_status w_mul_status;
    gfau_pkg::t_unit_status w_inv_status;

    assign w_accept    = i_valid && o_ready;
    assign w_start_mul = w_accept && (i_command == gfau_pkg::CMD_MUL);
    assign w_start_inv = w_accept && (i_command == gfau_pkg::CMD_INV);

    gfau_mul_serial u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_mul),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .o_status (w_mul_status)
    );

    gfau_inv_serial u_inv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_inv),
        .i_a      (i_operand_a),
        .o_status (w_inv_status)
    );

    // Pick the completion flag and value of the unit serving the current command.
    always_comb begin
        unique case (r_cmd)
            gfau_pkg::CMD_MUL: begin
                w_sel_done   = w_mul_status.done;
                w_sel_result = w_mul_status.result;
            end
            gfau_pkg::CMD_INV: begin
                w_sel_done   = w_inv_status.done;
                w_sel_result = w_inv_status.result;
            end
            default: begin
                w_sel_done   = 1'b1;
                w_sel_result = r_quick;
            end
        endcase
    end

    // The controller: idle takes a transaction, run waits for its result and
    // for room in the output register.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_quick     = r_quick;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            gfau_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_command;
                    n_quick = (i_command == gfau_pkg::CMD_ADD) ?
                              (i_operand_a ^ i_operand_b) : 8'h00;
                    n_state = gfau_pkg::S_RUN;
                end
            end
            gfau_pkg::S_RUN: begin
                if (w_sel_done && (!r_out_valid || i_ready)) begin
                    n_result    = w_sel_result;
                    n_out_valid = 1'b1;
                    n_state     = gfau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gfau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfau_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cmd       <= gfau_pkg::CMD_ADD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
        end
        r_quick  <= n_quick;
        r_result <= n_result;
    end

    assign o_ready        = (r_state == gfau_pkg::S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_field_result = r_result;

endmodule

/* src/gfau_mul_serial.sv */
// ============================================================================
// gfau_mul_serial
// Bit-serial GF(2^8) multiplier: one bit of operand b per cycle.
// ============================================================================
module gfau_mul_serial (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [7:0]             i_a,
    input  logic [7:0]             i_b,
    output gfau_pkg::t_unit_status o_status
);

    logic [7:0] r_acc, n_acc;
    logic [7:0] r_x, n_x;
    logic [7:0] r_y, n_y;
    logic [2:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic       r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_acc  = 8'h00;
            n_x    = i_a;
            n_y    = i_b;
            n_cnt  = 3'd0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_acc = r_y[0] ? (r_acc ^ r_x) : r_acc;
            n_x   = gfau_pkg::f_xtime(r_x);
            n_y   = {1'b0, r_y[7:1]};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_status.done   = r_done;
    assign o_status.result = r_acc;

endmodule

/* src/gfau_inv_serial.sv */
// ============================================================================
// gfau_inv_serial
// Binary extended-Euclid inverter over GF(2^8): one shift or one add per cycle.
// ============================================================================
module gfau_inv_serial (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [7:0]             i_a,
    output gfau_pkg::t_unit_status o_status
);

    // Invariants: g1 * a == u and g2 * a == v modulo the field polynomial.
    logic [8:0] r_u, n_u;
    logic [8:0] r_v, n_v;
    logic [7:0] r_g1, n_g1;
    logic [7:0] r_g2, n_g2;
    logic [7:0] r_res, n_res;
    logic       r_busy, n_busy;
    logic       r_done, n_done;

    always_comb begin
        n_u    = r_u;
        n_v    = r_v;
        n_g1   = r_g1;
        n_g2   = r_g2;
        n_res  = r_res;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_u    = {1'b0, i_a};
            n_v    = gfau_pkg::GF_POLY;
            n_g1   = 8'h01;
            n_g2   = 8'h00;
            n_res  = 8'h00;
            n_done = (i_a == 8'h00);
            n_busy = (i_a != 8'h00);
        end else if (r_busy) begin
            if (r_u == 9'd1) begin
                n_res  = r_g1;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_v == 9'd1) begin
                n_res  = r_g2;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_u[0]) begin
                n_u  = {1'b0, r_u[8:1]};
                n_g1 = gfau_pkg::f_half(r_g1);
            end else if (!r_v[0]) begin
                n_v  = {1'b0, r_v[8:1]};
                n_g2 = gfau_pkg::f_half(r_g2);
            end else if (gfau_pkg::f_degree(r_u) > gfau_pkg::f_degree(r_v)) begin
                n_u  = r_u ^ r_v;
                n_g1 = r_g1 ^ r_g2;
            end else begin
                n_v  = r_v ^ r_u;
                n_g2 = r_g2 ^ r_g1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_g1  <= n_g1;
        r_g2  <= n_g2;
        r_res <= n_res;
    end

    assign o_status.done   = r_done;
    assign o_status.result = r_res;

endmodule
